@@ hdl/rattr_pkg.sv @@
package rattr_pkg;

    localparam int HEADER_BYTES         = 20;
    localparam int VENDOR_SPECIFIC_TYPE = 26;
    localparam int CFG_INDEX_W          = 3;
    localparam int CFG_DATA_W           = 32;
    localparam int OFFSET_W             = 12;
    localparam int MIN_ATTR_LENGTH      = 2;
    localparam int MIN_VENDOR_LENGTH    = 8;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_TARGET_TYPE        = 3'd0,
        CFG_TARGET_VENDOR_ID   = 3'd1,
        CFG_TARGET_VENDOR_TYPE = 3'd2,
        CFG_TARGET_INSTANCE    = 3'd3,
        CFG_START_OFFSET       = 3'd4
    } cfg_reg_t;

    typedef struct packed {
        logic [7:0] packet_byte;
        logic       first_byte;
        logic       last_byte;
    } pkt_beat_t;

    typedef struct packed {
        logic                found;
        logic                malformed;
        logic [OFFSET_W-1:0] match_offset;
        logic [7:0]          match_length;
        logic [OFFSET_W-1:0] next_offset;
    } result_t;

    typedef struct packed {
        logic [7:0]          target_type;
        logic [31:0]         target_vendor_id;
        logic [7:0]          target_vendor_type;
        logic [7:0]          target_instance;
        logic [OFFSET_W-1:0] start_offset;
    } search_cfg_t;

endpackage

@@ hdl/rattr_cfg.sv @@
module rattr_cfg (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  wr_en,
    input  logic [rattr_pkg::CFG_INDEX_W-1:0]     wr_index,
    input  logic [rattr_pkg::CFG_DATA_W-1:0]      wr_data,
    output rattr_pkg::search_cfg_t                cfg
);
    import rattr_pkg::*;

    search_cfg_t cfg_reg;
    search_cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (cfg_reg_t'(wr_index))
                CFG_TARGET_TYPE:        cfg_next.target_type        = wr_data[7:0];
                CFG_TARGET_VENDOR_ID:   cfg_next.target_vendor_id   = wr_data[31:0];
                CFG_TARGET_VENDOR_TYPE: cfg_next.target_vendor_type = wr_data[7:0];
                CFG_TARGET_INSTANCE:    cfg_next.target_instance    = wr_data[7:0];
                CFG_START_OFFSET:       cfg_next.start_offset       = wr_data[OFFSET_W-1:0];
                default:                cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

@@ hdl/rattr_walk.sv @@
module rattr_walk #(
    parameter int MAX_PACKET_BYTES = 4096
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   step,
    input  rattr_pkg::pkt_beat_t   beat,
    input  rattr_pkg::search_cfg_t cfg,
    output logic                   emit,
    output rattr_pkg::result_t     result
);
    import rattr_pkg::*;

    localparam int POS_W  = $clog2(MAX_PACKET_BYTES + 1);
    localparam int ATTR_W = (POS_W > OFFSET_W) ? POS_W : OFFSET_W;
    localparam int CMP_W  = ((ATTR_W > 16) ? ATTR_W : 16) + 1;
    localparam int WALK_LIMIT = MAX_PACKET_BYTES - HEADER_BYTES;

    logic [POS_W-1:0]  pos_reg,    pos_next,    cur_pos;
    logic [15:0]       dlen_reg,   dlen_next,   cur_dlen;
    logic [ATTR_W-1:0] astart_reg, astart_next, cur_astart;
    logic [7:0]        atype_reg,  atype_next,  cur_atype;
    logic [7:0]        alen_reg,   alen_next,   cur_alen;
    logic [31:0]       vid_reg,    vid_next,    cur_vid;
    logic [7:0]        vtype_reg,  vtype_next,  cur_vtype;
    logic [7:0]        count_reg,  count_next,  cur_count;
    logic              done_reg,   done_next,   cur_done;
    logic              active_reg, active_next, cur_active;

    logic [CMP_W-1:0]  p_ext;
    logic [CMP_W-1:0]  as_ext;
    logic [CMP_W-1:0]  plen_ext;
    logic [CMP_W-1:0]  rel_pos;
    logic [CMP_W-1:0]  adv_sum;
    logic              adv;
    logic              vendor_hit;
    logic [7:0]        b;

    function automatic logic [OFFSET_W-1:0] sat_offset(input logic [CMP_W-1:0] v);
        logic [OFFSET_W-1:0] r;
        if (v > CMP_W'((1 << OFFSET_W) - 1))
            r = '1;
        else
            r = v[OFFSET_W-1:0];
        return r;
    endfunction

    always_comb
    begin
        b = beat.packet_byte;

        // a new packet starts from a clean slate
        if (beat.first_byte)
        begin
            cur_pos    = '0;
            cur_dlen   = '0;
            cur_astart = ATTR_W'(cfg.start_offset);
            cur_atype  = '0;
            cur_alen   = '0;
            cur_vid    = '0;
            cur_vtype  = '0;
            cur_count  = '0;
            cur_done   = 1'b0;
            cur_active = 1'b1;
        end
        else
        begin
            cur_pos    = pos_reg;
            cur_dlen   = dlen_reg;
            cur_astart = astart_reg;
            cur_atype  = atype_reg;
            cur_alen   = alen_reg;
            cur_vid    = vid_reg;
            cur_vtype  = vtype_reg;
            cur_count  = count_reg;
            cur_done   = done_reg;
            cur_active = active_reg;
        end

        pos_next    = cur_pos;
        dlen_next   = cur_dlen;
        astart_next = cur_astart;
        atype_next  = cur_atype;
        alen_next   = cur_alen;
        vid_next    = cur_vid;
        vtype_next  = cur_vtype;
        count_next  = cur_count;
        done_next   = cur_done;
        active_next = cur_active;

        emit       = 1'b0;
        result     = '0;
        adv        = 1'b0;
        vendor_hit = (cur_vid == cfg.target_vendor_id) &&
                     (cur_vtype == cfg.target_vendor_type);

        p_ext    = CMP_W'(cur_pos) - CMP_W'(HEADER_BYTES);
        as_ext   = CMP_W'(cur_astart);
        plen_ext = (cur_dlen >= 16'(HEADER_BYTES)) ?
                   CMP_W'(cur_dlen) - CMP_W'(HEADER_BYTES) : '0;
        rel_pos  = p_ext - as_ext;

        if (!cur_done)
        begin
            if (cur_pos < POS_W'(MAX_PACKET_BYTES))
            begin
                pos_next = cur_pos + POS_W'(1);
                if (cur_pos == POS_W'(2))
                    dlen_next = {b, cur_dlen[7:0]};
                else if (cur_pos == POS_W'(3))
                    dlen_next = {cur_dlen[15:8], b};

                if ((cur_pos >= POS_W'(HEADER_BYTES)) && cur_active && (p_ext >= as_ext))
                begin
                    if (rel_pos == '0)
                    begin
                        if (as_ext >= plen_ext)
                            active_next = 1'b0;
                        else
                            atype_next = b;
                    end
                    else if (rel_pos == CMP_W'(1))
                    begin
                        alen_next = b;
                        if (b < 8'(MIN_ATTR_LENGTH))
                        begin
                            active_next      = 1'b0;
                            emit             = 1'b1;
                            result.malformed = 1'b1;
                        end
                        else if (cur_atype != cfg.target_type)
                        begin
                            adv = 1'b1;
                        end
                        else if (cur_atype != 8'(VENDOR_SPECIFIC_TYPE))
                        begin
                            if (cur_count == cfg.target_instance)
                            begin
                                emit                = 1'b1;
                                result.found        = 1'b1;
                                result.match_offset = sat_offset(as_ext);
                                result.match_length = b;
                                result.next_offset  = sat_offset(as_ext + CMP_W'(b));
                            end
                            else
                            begin
                                if (cur_count != 8'hFF)
                                    count_next = cur_count + 8'd1;
                                adv = 1'b1;
                            end
                        end
                        else if (b < 8'(MIN_VENDOR_LENGTH))
                        begin
                            adv = 1'b1;
                        end
                    end
                    else if ((cur_atype == 8'(VENDOR_SPECIFIC_TYPE)) &&
                             (cur_atype == cfg.target_type) && (rel_pos <= CMP_W'(7)))
                    begin
                        if (rel_pos <= CMP_W'(5))
                        begin
                            vid_next = {cur_vid[23:0], b};
                        end
                        else if (rel_pos == CMP_W'(6))
                        begin
                            vtype_next = b;
                        end
                        else if (vendor_hit && (cur_count == cfg.target_instance))
                        begin
                            emit                = 1'b1;
                            result.found        = 1'b1;
                            result.match_offset = sat_offset(as_ext + CMP_W'(6));
                            result.match_length = b;
                            result.next_offset  = sat_offset(as_ext + CMP_W'(cur_alen));
                        end
                        else
                        begin
                            if (vendor_hit && (cur_count != 8'hFF))
                                count_next = cur_count + 8'd1;
                            adv = 1'b1;
                        end
                    end
                end
            end

            // end of packet without an earlier result
            if (!emit && beat.last_byte)
            begin
                emit   = 1'b1;
                result = '0;
            end
        end

        adv_sum = as_ext + CMP_W'(alen_next);
        if (adv)
        begin
            if (adv_sum >= CMP_W'(WALK_LIMIT))
                active_next = 1'b0;
            else
                astart_next = adv_sum[ATTR_W-1:0];
        end

        if (emit)
            done_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg    <= '0;
            dlen_reg   <= '0;
            astart_reg <= '0;
            atype_reg  <= '0;
            alen_reg   <= '0;
            vid_reg    <= '0;
            vtype_reg  <= '0;
            count_reg  <= '0;
            done_reg   <= 1'b0;
            active_reg <= 1'b0;
        end
        else if (step)
        begin
            pos_reg    <= pos_next;
            dlen_reg   <= dlen_next;
            astart_reg <= astart_next;
            atype_reg  <= atype_next;
            alen_reg   <= alen_next;
            vid_reg    <= vid_next;
            vtype_reg  <= vtype_next;
            count_reg  <= count_next;
            done_reg   <= done_next;
            active_reg <= active_next;
        end
    end

endmodule

@@ hdl/radius_attribute_finder.sv @@
// RADIUS attribute search, one packet byte per beat.
//
// pkt channel: one beat per packet byte, header included. first_byte marks
// the start of a packet and reloads the walk from start_offset; last_byte
// closes the packet. res channel: at most one beat per packet, either the
// requested attribute (found), a malformed stop, or not found at last_byte.
// cfg channel: register writes by index, always ready; write only while the
// block is idle.
//
// A byte taken into the input register is walked combinationally; its result
// goes into the result register as the walk steps. Throughput: one byte per
// cycle unless the result stalls, set by the combinational walker update. A
// stalled result holds; an empty input register still takes one more byte,
// then pkt_ready drops until the result is taken.
//
// Reset clears the configuration to zero, the walk state and the valid
// flags of both registers; bytes seen before any first_byte match nothing,
// as the walk is inactive, though a last_byte still gives a not-found result.
module radius_attribute_finder #(
    parameter int MAX_PACKET_BYTES = 4096
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              pkt_valid,
    output logic                              pkt_ready,
    input  rattr_pkg::pkt_beat_t              pkt_data,
    output logic                              res_valid,
    input  logic                              res_ready,
    output rattr_pkg::result_t                res_data,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [rattr_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [rattr_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import rattr_pkg::*;

    search_cfg_t cfg;
    pkt_beat_t   beat_reg;
    logic        beat_valid_reg;
    logic        beat_valid_next;
    result_t     res_reg;
    logic        res_valid_reg;
    logic        res_valid_next;
    result_t     walk_result;
    logic        walk_emit;
    logic        step;

    assign cfg_ready = 1'b1;

    rattr_cfg u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    // advance the walk only when the result register can take what it yields
    assign step      = beat_valid_reg && (!res_valid_reg || res_ready);
    assign pkt_ready = !beat_valid_reg || step;

    rattr_walk #(
        .MAX_PACKET_BYTES (MAX_PACKET_BYTES)
    ) u_walk (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (step),
        .beat   (beat_reg),
        .cfg    (cfg),
        .emit   (walk_emit),
        .result (walk_result)
    );

    always_comb
    begin
        beat_valid_next = beat_valid_reg;
        if (pkt_valid && pkt_ready)
            beat_valid_next = 1'b1;
        else if (step)
            beat_valid_next = 1'b0;

        res_valid_next = res_valid_reg;
        if (step)
            res_valid_next = walk_emit;
        else if (res_ready)
            res_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            beat_valid_reg <= 1'b0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            beat_valid_reg <= beat_valid_next;
            res_valid_reg  <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pkt_valid && pkt_ready)
            beat_reg <= pkt_data;
        if (step && walk_emit)
            res_reg <= walk_result;
    end

    assign res_valid = res_valid_reg;
    assign res_data  = res_reg;

`ifndef SYNTHESIS
    a_found_not_malformed: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> !(res_data.found && res_data.malformed))
        else $error("result flags both found and malformed");

    a_miss_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && !res_data.found) |->
        (res_data.match_offset == '0 && res_data.match_length == '0 &&
         res_data.next_offset == '0))
        else $error("miss result carries nonzero fields");

    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        !pkt_ready |-> (beat_valid_reg && res_valid_reg && !res_ready))
        else $error("input stalled without a full pipeline");

    a_stalled_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && !res_ready) |=> (res_valid_reg && $stable(res_reg)))
        else $error("pending result lost or changed");
`endif

endmodule
